@@ hw/rtl/sirt_pkg.sv @@
// ----------------------------------------------------------------------------
// sirt_pkg
// Shared types and codes for the sorted interval reservation table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sirt_pkg;

	localparam int TIME_W  = 11;
	localparam int ROOM_W  = 16;
	localparam int REQ_W   = 2;
	localparam int STAT_W  = 3;
	localparam int SLOT_W  = 5;
	localparam int COUNT_W = 6;

	// 24 hours in unsigned q5.6
	localparam logic [TIME_W-1:0] DAY_END = 11'd1536;

	localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
	localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
	localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;

	localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
	localparam logic [STAT_W-1:0] STAT_INVALID   = 3'd1;
	localparam logic [STAT_W-1:0] STAT_OVERLAP   = 3'd2;
	localparam logic [STAT_W-1:0] STAT_FULL      = 3'd3;
	localparam logic [STAT_W-1:0] STAT_REMOVED   = 3'd4;
	localparam logic [STAT_W-1:0] STAT_FOUND     = 3'd5;
	localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd6;

	typedef struct packed {
		logic [TIME_W-1:0] beg_time;
		logic [TIME_W-1:0] fin_time;
		logic [ROOM_W-1:0] room_tag;
	} entry_t;

	typedef struct packed {
		logic [STAT_W-1:0]  status;
		logic [SLOT_W-1:0]  slot_index;
		logic [TIME_W-1:0]  found_end;
		logic [ROOM_W-1:0]  found_room;
		logic [COUNT_W-1:0] entry_count;
	} rsp_t;

endpackage

@@ hw/rtl/sirt_entry_ram.sv @@
// ----------------------------------------------------------------------------
// sirt_entry_ram
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sirt_entry_ram #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output sirt_pkg::entry_t rd_data,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  sirt_pkg::entry_t wr_data
);

	sirt_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

@@ hw/rtl/sirt_seq.sv @@
// ----------------------------------------------------------------------------
// sirt_seq
// Request sequencer: scans the entry memory, decides the slot, and shifts
// entries up or down one place per cycle through the memory ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sirt_seq #(
	parameter int DEPTH = 32,
	parameter int IW    = 5,
	parameter int CW    = 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [sirt_pkg::REQ_W-1:0]        req_type,
	input  logic [sirt_pkg::TIME_W-1:0]       begin_time,
	input  logic [sirt_pkg::TIME_W-1:0]       end_time,
	input  logic [sirt_pkg::ROOM_W-1:0]       room,
	input  logic                              rsp_free,
	output logic                              rsp_load,
	output sirt_pkg::rsp_t                    rsp,
	output logic                              rd_en,
	output logic [IW-1:0]                     rd_addr,
	input  sirt_pkg::entry_t                  rd_data,
	output logic                              wr_en,
	output logic [IW-1:0]                     wr_addr,
	output sirt_pkg::entry_t                  wr_data
);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_SHUP   = 3'd3;
	localparam logic [2:0] S_SHDN   = 3'd4;
	localparam logic [2:0] S_WRITE  = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	logic [2:0]                        state_q;
	logic [sirt_pkg::REQ_W-1:0]        type_q;
	logic [sirt_pkg::TIME_W-1:0]       beg_q;
	logic [sirt_pkg::TIME_W-1:0]       fin_q;
	logic [sirt_pkg::ROOM_W-1:0]       room_q;
	logic [CW-1:0]                     count_q;
	logic [CW-1:0]                     rd_ptr_q;
	logic [CW-1:0]                     slot_q;
	logic                              iss_done_q;
	logic                              vld_s1;
	logic [IW-1:0]                     idx_s1;
	logic [sirt_pkg::TIME_W-1:0]       prev_end_q;
	logic                              first_ok_q;
	logic                              last_ok_q;
	logic                              inner_ok_q;
	logic [IW-1:0]                     inner_slot_q;
	sirt_pkg::rsp_t                    rsp_q;

	logic                              last_s1;
	logic                              dec_found;
	logic [CW-1:0]                     dec_slot;

	assign req_ready = (state_q == S_IDLE);
	assign rsp_load  = (state_q == S_DONE) && rsp_free;
	assign rsp       = rsp_q;
	assign last_s1   = vld_s1 && (CW'(idx_s1) == count_q - CW'(1));

	// gap choice after the scan
	always_comb begin
		dec_found = 1'b1;
		dec_slot  = '0;
		priority if (last_ok_q) begin
			dec_slot = count_q;
		end else if (first_ok_q) begin
			dec_slot = '0;
		end else if (inner_ok_q) begin
			dec_slot = CW'(inner_slot_q);
		end else begin
			dec_found = 1'b0;
		end
	end

	// memory port control
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rd_ptr_q[IW-1:0];
		wr_en   = 1'b0;
		wr_addr = slot_q[IW-1:0];
		wr_data = rd_data;
		unique case (state_q)
			S_SCAN: begin
				rd_en = (rd_ptr_q < count_q);
			end
			S_SHUP: begin
				rd_en   = !iss_done_q;
				wr_en   = vld_s1;
				wr_addr = idx_s1 + IW'(1);
			end
			S_SHDN: begin
				rd_en   = (rd_ptr_q < count_q);
				wr_en   = vld_s1;
				wr_addr = idx_s1 - IW'(1);
			end
			S_WRITE: begin
				wr_en   = 1'b1;
				wr_data = '{beg_time: beg_q, fin_time: fin_q, room_tag: room_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			type_q       <= '0;
			beg_q        <= '0;
			fin_q        <= '0;
			room_q       <= '0;
			count_q      <= '0;
			rd_ptr_q     <= '0;
			slot_q       <= '0;
			iss_done_q   <= 1'b0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			prev_end_q   <= '0;
			first_ok_q   <= 1'b0;
			last_ok_q    <= 1'b0;
			inner_ok_q   <= 1'b0;
			inner_slot_q <= '0;
			rsp_q        <= '0;
		end else begin
			vld_s1 <= rd_en;
			idx_s1 <= rd_ptr_q[IW-1:0];
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						type_q     <= req_type;
						beg_q      <= begin_time;
						fin_q      <= end_time;
						room_q     <= room;
						rd_ptr_q   <= '0;
						first_ok_q <= 1'b0;
						last_ok_q  <= 1'b0;
						inner_ok_q <= 1'b0;
						slot_q     <= '0;
						rsp_q      <= '{sirt_pkg::STAT_NOT_FOUND, '0, '0, '0,
							sirt_pkg::COUNT_W'(count_q)};
						if (req_type == sirt_pkg::REQ_INSERT) begin
							if (end_time > sirt_pkg::DAY_END || begin_time >= end_time) begin
								rsp_q.status <= sirt_pkg::STAT_INVALID;
								state_q      <= S_DONE;
							end else if (count_q == '0) begin
								state_q <= S_WRITE;
							end else begin
								state_q <= S_SCAN;
							end
						end else if (req_type == sirt_pkg::REQ_REMOVE ||
								req_type == sirt_pkg::REQ_FIND) begin
							state_q <= (count_q == '0) ? S_DONE : S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (rd_en) begin
						rd_ptr_q <= rd_ptr_q + CW'(1);
					end
					if (vld_s1) begin
						if (type_q == sirt_pkg::REQ_INSERT) begin
							if (idx_s1 == '0) begin
								first_ok_q <= (rd_data.beg_time >= fin_q);
							end else if (!inner_ok_q && beg_q >= prev_end_q &&
									fin_q <= rd_data.beg_time) begin
								inner_ok_q   <= 1'b1;
								inner_slot_q <= idx_s1;
							end
							prev_end_q <= rd_data.fin_time;
							if (last_s1) begin
								last_ok_q <= (rd_data.fin_time <= beg_q);
								state_q   <= S_DECIDE;
							end
						end else if (rd_data.beg_time == beg_q) begin
							slot_q <= CW'(idx_s1);
							if (type_q == sirt_pkg::REQ_FIND) begin
								rsp_q <= '{sirt_pkg::STAT_FOUND,
									sirt_pkg::SLOT_W'(idx_s1), rd_data.fin_time,
									rd_data.room_tag, sirt_pkg::COUNT_W'(count_q)};
								state_q <= S_DONE;
							end else if (last_s1) begin
								count_q <= count_q - CW'(1);
								rsp_q   <= '{sirt_pkg::STAT_REMOVED,
									sirt_pkg::SLOT_W'(idx_s1), '0, '0,
									sirt_pkg::COUNT_W'(count_q - CW'(1))};
								state_q <= S_DONE;
							end else begin
								rd_ptr_q <= CW'(idx_s1) + CW'(1);
								vld_s1   <= 1'b0;
								state_q  <= S_SHDN;
							end
						end else if (last_s1) begin
							state_q <= S_DONE;
						end
					end
				end
				S_DECIDE: begin
					if (!dec_found) begin
						rsp_q.status <= sirt_pkg::STAT_OVERLAP;
						state_q      <= S_DONE;
					end else if (count_q == CW'(DEPTH)) begin
						rsp_q.status <= sirt_pkg::STAT_FULL;
						state_q      <= S_DONE;
					end else begin
						slot_q <= dec_slot;
						if (dec_slot == count_q) begin
							state_q <= S_WRITE;
						end else begin
							rd_ptr_q   <= count_q - CW'(1);
							iss_done_q <= 1'b0;
							vld_s1     <= 1'b0;
							state_q    <= S_SHUP;
						end
					end
				end
				S_SHUP: begin
					if (rd_en) begin
						rd_ptr_q <= rd_ptr_q - CW'(1);
						if (rd_ptr_q == slot_q) begin
							iss_done_q <= 1'b1;
						end
					end
					if (vld_s1 && CW'(idx_s1) == slot_q) begin
						state_q <= S_WRITE;
					end
				end
				S_SHDN: begin
					if (rd_en) begin
						rd_ptr_q <= rd_ptr_q + CW'(1);
					end
					if (last_s1) begin
						count_q <= count_q - CW'(1);
						rsp_q   <= '{sirt_pkg::STAT_REMOVED, sirt_pkg::SLOT_W'(slot_q),
							'0, '0, sirt_pkg::COUNT_W'(count_q - CW'(1))};
						state_q <= S_DONE;
					end
				end
				S_WRITE: begin
					count_q <= count_q + CW'(1);
					rsp_q   <= '{sirt_pkg::STAT_INSERTED, sirt_pkg::SLOT_W'(slot_q),
						'0, '0, sirt_pkg::COUNT_W'(count_q + CW'(1))};
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/sorted_interval_reservation_table_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_interval_reservation_table_unit
// Keeps up to TABLE_DEPTH non-overlapping intervals with room tags, sorted by
// start time, in one entry memory with one read and one write port (read data
// registered). One request is worked at a time and answers with one response.
// Insert scans all n stored entries, picks the slot, then moves the later
// entries up one place per cycle and writes the new one. Find scans until the
// first match. Remove adds a downward move of the later entries, one per
// cycle. A bad interval or an unknown request type answers without a scan.
// A response register lets the next request be taken while the last
// response waits. The memory needs no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_interval_reservation_table_unit #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_ready,
	input  logic [sirt_pkg::REQ_W-1:0]          req_type,
	input  logic [sirt_pkg::TIME_W-1:0]         begin_time,
	input  logic [sirt_pkg::TIME_W-1:0]         end_time,
	input  logic [sirt_pkg::ROOM_W-1:0]         room,
	output logic                                rsp_valid,
	input  logic                                rsp_ready,
	output logic [sirt_pkg::STAT_W-1:0]         status,
	output logic [sirt_pkg::SLOT_W-1:0]         slot_index,
	output logic [sirt_pkg::TIME_W-1:0]         found_end,
	output logic [sirt_pkg::ROOM_W-1:0]         found_room,
	output logic [sirt_pkg::COUNT_W-1:0]        entry_count
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic             rd_en;
	logic [IW-1:0]    rd_addr;
	sirt_pkg::entry_t rd_data;
	logic             wr_en;
	logic [IW-1:0]    wr_addr;
	sirt_pkg::entry_t wr_data;
	logic             rsp_free;
	logic             rsp_load;
	sirt_pkg::rsp_t   rsp_next;
	sirt_pkg::rsp_t   rsp_q;
	logic             rsp_valid_q;

	sirt_entry_ram #(
		.DEPTH (TABLE_DEPTH),
		.AW    (IW)
	) u_ram (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	sirt_seq #(
		.DEPTH (TABLE_DEPTH),
		.IW    (IW),
		.CW    (CW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_type   (req_type),
		.begin_time (begin_time),
		.end_time   (end_time),
		.room       (room),
		.rsp_free   (rsp_free),
		.rsp_load   (rsp_load),
		.rsp        (rsp_next),
		.rd_en      (rd_en),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data)
	);

	// response register
	assign rsp_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else if (rsp_load) begin
			rsp_valid_q <= 1'b1;
			rsp_q       <= rsp_next;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = rsp_q.status;
	assign slot_index  = rsp_q.slot_index;
	assign found_end   = rsp_q.found_end;
	assign found_room  = rsp_q.found_room;
	assign entry_count = rsp_q.entry_count;

endmodule
